>>> sv/dda_pkg.sv
package dda_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
    localparam int STEP_BITS  = FRAC_BITS + 2;
    localparam int LEFT_BITS  = COORD_BITS + 1;
    localparam int COLOR_BITS = 32;

    // A line longer than this is drawn over several input beats.
    localparam int MAX_BURST  = 64;
    localparam int BURST_BITS = $clog2(MAX_BURST);
    localparam int DCNT_BITS  = $clog2(ACC_BITS);

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 32'hFF0000FF;
    localparam logic [ACC_BITS-1:0]   ROUND_HALF  = ACC_BITS'(1) << (FRAC_BITS - 1);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [ACC_BITS-1:0]   acc_t;
    typedef logic [STEP_BITS-1:0]  step_t;

endpackage

>>> sv/dda_line_rasterizer_top.sv
// DDA line rasterizer. Each input beat carries a line's start and end point; the block
// emits one pixel per step of the longer axis, starting at the start point and stopping
// one short of the end point, with the line color register attached. A zero-length line
// emits nothing. A new line first runs the shared restoring divider (one quotient bit
// per cycle, x increment then y increment), then emits one pixel per cycle while the output
// side keeps up. At most 64 pixels are emitted per input beat; a longer line continues on
// the next input beat, whose payload is then ignored. The block is ready for input only
// between lines or bursts, and may take the next beat while the last pixel still waits on
// the output.
module dda_line_rasterizer_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          line_color_we,
    input  logic [dda_pkg::COLOR_BITS-1:0] line_color_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dda_pkg::COORD_BITS-1:0] s_start_x,
    input  logic [dda_pkg::COORD_BITS-1:0] s_start_y,
    input  logic [dda_pkg::COORD_BITS-1:0] s_end_x,
    input  logic [dda_pkg::COORD_BITS-1:0] s_end_y,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dda_pkg::COORD_BITS-1:0] m_pixel_x,
    output logic [dda_pkg::COORD_BITS-1:0] m_pixel_y,
    output logic [dda_pkg::COLOR_BITS-1:0] m_pixel_color,
    output logic                          m_last_pixel
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int CB = dda_pkg::COORD_BITS;
    localparam int AB = dda_pkg::ACC_BITS;
    localparam int SB = dda_pkg::STEP_BITS;
    localparam int LB = dda_pkg::LEFT_BITS;

    logic [1:0]                    state_reg, state_next;
    logic [dda_pkg::COLOR_BITS-1:0] color_reg;

    dda_pkg::acc_t                 pos_x_reg, pos_x_next;
    dda_pkg::acc_t                 pos_y_reg, pos_y_next;
    dda_pkg::step_t                step_x_reg, step_x_next;
    dda_pkg::step_t                step_y_reg, step_y_next;
    logic [LB-1:0]                 left_reg, left_next;
    logic [dda_pkg::BURST_BITS-1:0] burst_reg, burst_next;

    // Divider state.
    dda_pkg::coord_t               n_reg, n_next;
    dda_pkg::coord_t               mag_y_reg, mag_y_next;
    logic                          neg_x_reg, neg_x_next;
    logic                          neg_y_reg, neg_y_next;
    logic                          axis_reg, axis_next;
    logic [dda_pkg::DCNT_BITS-1:0] dcnt_reg, dcnt_next;
    dda_pkg::coord_t               rem_reg, rem_next;
    dda_pkg::acc_t                 quot_reg, quot_next;

    logic                          m_valid_reg, m_valid_next;
    dda_pkg::coord_t               m_x_reg, m_x_next;
    dda_pkg::coord_t               m_y_reg, m_y_next;
    logic [dda_pkg::COLOR_BITS-1:0] m_color_reg, m_color_next;
    logic                          m_last_reg, m_last_next;

    dda_pkg::coord_t               ax, ay, n_in;
    logic [CB:0]                   trial;
    logic                          fits;
    dda_pkg::acc_t                 q_full;
    dda_pkg::step_t                q_step, q_signed;
    dda_pkg::acc_t                 rnd_x, rnd_y;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_x_reg;
    assign m_pixel_y     = m_y_reg;
    assign m_pixel_color = m_color_reg;
    assign m_last_pixel  = m_last_reg;

    always_comb begin
        ax   = (s_end_x >= s_start_x) ? s_end_x - s_start_x : s_start_x - s_end_x;
        ay   = (s_end_y >= s_start_y) ? s_end_y - s_start_y : s_start_y - s_end_y;
        n_in = (ax >= ay) ? ax : ay;

        // One restoring division step: bring down a dividend bit, subtract if it fits.
        trial    = {rem_reg, quot_reg[AB-1]};
        fits     = trial >= {1'b0, n_reg};
        q_full   = {quot_reg[AB-2:0], fits};
        q_step   = q_full[SB-1:0];
        q_signed = (axis_reg ? neg_y_reg : neg_x_reg) ? SB'(0) - q_step : q_step;

        rnd_x = pos_x_reg + dda_pkg::ROUND_HALF;
        rnd_y = pos_y_reg + dda_pkg::ROUND_HALF;
    end

    always_comb begin
        state_next   = state_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        left_next    = left_reg;
        burst_next   = burst_reg;
        n_next       = n_reg;
        mag_y_next   = mag_y_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        axis_next    = axis_reg;
        dcnt_next    = dcnt_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_color_next = m_color_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    burst_next = '0;
                    if (left_reg != '0) begin
                        state_next = ST_EMIT;
                    end else if (n_in != '0) begin
                        state_next = ST_DIV;
                        pos_x_next = {s_start_x, {dda_pkg::FRAC_BITS{1'b0}}};
                        pos_y_next = {s_start_y, {dda_pkg::FRAC_BITS{1'b0}}};
                        left_next  = LB'(n_in);
                        n_next     = n_in;
                        mag_y_next = ay;
                        neg_x_next = s_end_x < s_start_x;
                        neg_y_next = s_end_y < s_start_y;
                        axis_next  = 1'b0;
                        dcnt_next  = '0;
                        rem_next   = '0;
                        quot_next  = {ax, {dda_pkg::FRAC_BITS{1'b0}}};
                    end
                end
            end
            ST_DIV: begin
                rem_next  = fits ? CB'(trial - {1'b0, n_reg}) : trial[CB-1:0];
                quot_next = q_full;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == dda_pkg::DCNT_BITS'(AB - 1)) begin
                    dcnt_next = '0;
                    rem_next  = '0;
                    if (!axis_reg) begin
                        step_x_next = q_signed;
                        axis_next   = 1'b1;
                        quot_next   = {mag_y_reg, {dda_pkg::FRAC_BITS{1'b0}}};
                    end else begin
                        step_y_next = q_signed;
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_x_next     = rnd_x[AB-1:dda_pkg::FRAC_BITS];
                    m_y_next     = rnd_y[AB-1:dda_pkg::FRAC_BITS];
                    m_color_next = color_reg;
                    m_last_next  = (left_reg == LB'(1));
                    left_next    = left_reg - 1'b1;
                    pos_x_next   = pos_x_reg + {{(AB-SB){step_x_reg[SB-1]}}, step_x_reg};
                    pos_y_next   = pos_y_reg + {{(AB-SB){step_y_reg[SB-1]}}, step_y_reg};
                    burst_next   = burst_reg + 1'b1;
                    if (left_reg == LB'(1) ||
                        burst_reg == dda_pkg::BURST_BITS'(dda_pkg::MAX_BURST - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            color_reg   <= dda_pkg::COLOR_RESET;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            step_x_reg  <= '0;
            step_y_reg  <= '0;
            left_reg    <= '0;
            burst_reg   <= '0;
            axis_reg    <= 1'b0;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (line_color_we) begin
                color_reg <= line_color_wdata;
            end
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            step_x_reg  <= step_x_next;
            step_y_reg  <= step_y_next;
            left_reg    <= left_next;
            burst_reg   <= burst_next;
            axis_reg    <= axis_next;
            dcnt_reg    <= dcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        mag_y_reg   <= mag_y_next;
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        m_x_reg     <= m_x_next;
        m_y_reg     <= m_y_next;
        m_color_reg <= m_color_next;
        m_last_reg  <= m_last_next;
    end

endmodule

>>> sv/dda_line_rasterizer_checker.sv
module dda_line_rasterizer_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [dda_pkg::COORD_BITS-1:0] m_pixel_x,
    input logic [dda_pkg::COORD_BITS-1:0] m_pixel_y,
    input logic [dda_pkg::COLOR_BITS-1:0] m_pixel_color,
    input logic                          m_last_pixel
);

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_x) && $stable(m_pixel_y) &&
            $stable(m_pixel_color) && $stable(m_last_pixel)))
        else $error("output beat changed while stalled");

    // After the final pixel of a line the next line needs its divide first.
    a_gap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_pixel) |=> !m_valid)
        else $error("pixel emitted right after the last pixel of a line");

    // Pixels are only produced while the block is busy with a line.
    a_rise_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("pixel appeared while the block was idle");

endmodule

bind dda_line_rasterizer_top dda_line_rasterizer_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_x     (m_pixel_x),
    .m_pixel_y     (m_pixel_y),
    .m_pixel_color (m_pixel_color),
    .m_last_pixel  (m_last_pixel)
);
